/* design/spmq_pkg.sv */
// Shared types and codes for the stable priority mailbox queue.
package spmq_pkg;

	localparam int unsigned PRIO_W = 8;
	localparam int unsigned MSG_W  = 16;

	localparam logic [1:0] MODE_DELIVER = 2'd0;
	localparam logic [1:0] MODE_CONSULT = 2'd1;

	localparam logic [2:0] ST_DELIVERED = 3'd0;
	localparam logic [2:0] ST_RETURNED  = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [PRIO_W-1:0] prio;
		logic [MSG_W-1:0]  msg;
	} cmd_t;

	typedef struct packed {
		logic              valid;
		logic [PRIO_W-1:0] prio;
		logic [MSG_W-1:0]  msg;
	} entry_t;

endpackage

/* design/spmq_cell.sv */
// One slot of the sorted shift chain: holds an entry, inserts or shifts per command.
module spmq_cell
	import spmq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  entry_t left,
	input  logic   left_keep,
	input  entry_t right,
	output entry_t entry,
	output logic   keep
);

	logic              valid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [MSG_W-1:0]  msg_q;

	assign entry = '{valid: valid_q, prio: prio_q, msg: msg_q};
	assign keep  = valid_q && (prio_q >= cmd.prio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CLEAR: valid_q <= 1'b0;
				OP_PUSH: begin
					if (!keep) begin
						valid_q <= left_keep ? 1'b1 : left.valid;
					end
				end
				OP_POP:  valid_q <= right.valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_PUSH: begin
				if (!keep) begin
					prio_q <= left_keep ? cmd.prio : left.prio;
					msg_q  <= left_keep ? cmd.msg : left.msg;
				end
			end
			OP_POP: begin
				prio_q <= right.prio;
				msg_q  <= right.msg;
			end
			default: begin
				prio_q <= prio_q;
				msg_q  <= msg_q;
			end
		endcase
	end

endmodule

/* design/stable_priority_mailbox_queue_top.sv */
// Top level of the stable priority mailbox queue.
//
// Requests arrive on the s_ channel: s_tuser carries the mode (deliver,
// consult, clear), s_tdata the priority and message handle. Each request
// gives exactly one result beat on the m_ channel: m_tuser carries the
// status, m_tdata the returned priority, handle and the empty flag.
// Entries sit in a chain of DEPTH cells sorted by priority, ties kept in
// arrival order. Every cell compares against the incoming priority at
// once, and on a deliver or consult all cells update together.
// The result beat is presented in the cycle after the request is accepted; one request
// is taken per cycle while the receiver keeps up.
// The result waits in an output register; a new request is accepted in the
// same cycle the waiting result is taken, and held off while it is not.
// Reset empties the queue and drops any waiting result.
module stable_priority_mailbox_queue_top
	import spmq_pkg::*;
#(
	parameter int unsigned DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [7:0] priority_req, [23:8] message_ref
	input  logic [1:0]  s_tuser,  // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] out_priority, [23:8] out_message_ref, [24] is_empty
	output logic [2:0]  m_tuser   // [2:0] status
);

	entry_t           cells [DEPTH];
	logic             keeps [DEPTH];
	logic [DEPTH-1:0] valid_vec;
	cmd_t             cmd;
	logic             in_acc;
	logic             full;

	logic              m_valid_q;
	logic [2:0]        status_q;
	logic [PRIO_W-1:0] prio_q;
	logic [MSG_W-1:0]  msg_q;
	logic              empty_q;

	logic [2:0]        status_d;
	logic [PRIO_W-1:0] prio_d;
	logic [MSG_W-1:0]  msg_d;
	logic              empty_d;

	assign s_tready = !m_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign full     = valid_vec[DEPTH-1];

	always_comb begin
		cmd.prio = s_tdata[7:0];
		cmd.msg  = s_tdata[23:8];
		cmd.op   = OP_NONE;
		status_d = ST_CLEARED;
		prio_d   = '0;
		msg_d    = '0;
		empty_d  = 1'b1;
		if (s_tuser[1]) begin
			cmd.op = in_acc ? OP_CLEAR : OP_NONE;
		end else if (s_tuser == MODE_DELIVER) begin
			empty_d = 1'b0;
			if (full) begin
				status_d = ST_FULL;
			end else begin
				status_d = ST_DELIVERED;
				cmd.op   = in_acc ? OP_PUSH : OP_NONE;
			end
		end else if (valid_vec[0]) begin
			status_d = ST_RETURNED;
			prio_d   = cells[0].prio;
			msg_d    = cells[0].msg;
			empty_d  = !valid_vec[1];
			cmd.op   = in_acc ? OP_POP : OP_NONE;
		end else begin
			status_d = ST_EMPTY;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left;
		entry_t right;
		logic   left_keep;

		if (i == 0) begin : g_first
			assign left      = '0;
			assign left_keep = 1'b1;
		end else begin : g_mid
			assign left      = cells[i-1];
			assign left_keep = keeps[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_inner
			assign right = cells[i+1];
		end

		spmq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left      (left),
			.left_keep (left_keep),
			.right     (right),
			.entry     (cells[i]),
			.keep      (keeps[i])
		);

		assign valid_vec[i] = cells[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_acc) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q <= status_d;
			prio_q   <= prio_d;
			msg_q    <= msg_d;
			empty_q  <= empty_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {7'd0, empty_q, msg_q, prio_q};

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec & (valid_vec + 1'b1)) == '0))
		else $error("occupied cells are not a contiguous run from the head");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_vec[1] |-> (cells[0].prio >= cells[1].prio))
		else $error("head entry outranked by the entry behind it");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser[1]) |=> (valid_vec == '0))
		else $error("clear left entries in the chain");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (s_tuser == MODE_DELIVER) && full) |=> (status_q == ST_FULL) && full)
		else $error("deliver to a full queue not refused");

endmodule
